// ----- rtl/met_pkg.sv -----
// ---------------------------------------------------------------------------
// met_pkg
// shared types and constants of the multi-slot event timer
// ---------------------------------------------------------------------------
package met_pkg;

    localparam int NUM_TIMERS_DEF = 16;
    localparam int CFG_W          = 5;
    localparam logic [CFG_W-1:0] ACTIVE_RST = CFG_W'(16);

    localparam int EVENT_W   = 8;
    localparam int CLIENT_W  = 4;
    localparam int AMOUNT_W  = 24;
    localparam int ELAPSED_W = 25;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_STOP  = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    typedef struct packed {
        logic [1:0]          operation;
        logic [EVENT_W-1:0]  event_id;
        logic [CLIENT_W-1:0] client_id;
        logic [AMOUNT_W-1:0] amount_ms;
        logic                periodic;
    } t_in_item;

    typedef struct packed {
        logic [EVENT_W-1:0]  fired_event;
        logic [CLIENT_W-1:0] fired_client;
        logic                last;
    } t_result;

    typedef struct packed {
        logic [EVENT_W-1:0]   event_id;
        logic [CLIENT_W-1:0]  client_id;
        logic [AMOUNT_W-1:0]  duration;
        logic                 repeat_en;
        logic [ELAPSED_W-1:0] elapsed;
    } t_slot;

    localparam int SLOT_W = $bits(t_slot);

endpackage

// ----- rtl/met_ram.sv -----
// ---------------------------------------------------------------------------
// met_ram
// generic simple dual-port ram, one write port, one registered read port
// ---------------------------------------------------------------------------
module met_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/multi_slot_event_timer_top.sv -----
// ---------------------------------------------------------------------------
// multi_slot_event_timer_top
// table of one-shot and periodic timer slots, scanned one slot per cycle
// ---------------------------------------------------------------------------
// busy: from a start transaction until the first n slots are scanned, where n is
//   min(active_timers, NUM_TIMERS); start and stop end early at their slot
// throughput: one slot per cycle through the shared slot evaluator and the
//   slot ram read port; a new item is taken only while idle
// results leave one per cycle on o_res_valid and cannot be stalled
// reset: all slots free, active_timers back to 16; slot ram is not cleared
// ---------------------------------------------------------------------------
module multi_slot_event_timer_top
    import met_pkg::*;
#(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  t_in_item         i_item,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_data,
    output logic             o_res_valid,
    output t_result          o_res
);

    localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CW = $clog2(NUM_TIMERS + 1);
    localparam int NW = (CW > CFG_W) ? CW : CFG_W;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    t_state               r_state;
    logic [CFG_W-1:0]     r_active;
    logic [NUM_TIMERS-1:0] r_valid;
    t_in_item             r_item;
    logic [IW-1:0]        r_issue_idx;
    logic [IW-1:0]        r_last_idx;
    logic                 r_issue_on;
    logic [IW-1:0]        r_ev_idx;
    logic                 r_ev_on;
    logic                 r_pend_vld;
    t_result              r_pend;
    logic                 r_out_vld;
    t_result              r_out;

    logic [NW-1:0]        scan_n;
    logic [NW-1:0]        act_ext;
    t_slot                rd_slot;
    t_slot                wr_slot;
    logic                 wr_en;
    logic                 v_bit;
    logic                 hit;
    logic                 fire;
    logic                 adv;
    logic                 stop_scan;
    logic                 scan_done;
    logic [ELAPSED_W-1:0] sum;
    logic [ELAPSED_W:0]   diff;
    logic [SLOT_W-1:0]    ram_q;

    assign act_ext = NW'(r_active);
    assign scan_n  = (act_ext > NW'(NUM_TIMERS)) ? NW'(NUM_TIMERS) : act_ext;

    met_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (NUM_TIMERS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_ev_idx),
        .i_wdata (wr_slot),
        .i_raddr (r_issue_idx),
        .o_rdata (ram_q)
    );

    assign rd_slot = t_slot'(ram_q);
    assign v_bit   = r_valid[r_ev_idx];

    // shared slot evaluator
    always_comb begin
        sum   = rd_slot.elapsed + ELAPSED_W'(r_item.amount_ms);
        diff  = {1'b0, rd_slot.elapsed} + (ELAPSED_W+1)'(r_item.amount_ms)
              - (ELAPSED_W+1)'(rd_slot.duration);
        adv   = v_bit && (rd_slot.elapsed < ELAPSED_W'(rd_slot.duration));
        hit   = 1'b0;
        fire  = 1'b0;
        wr_en = 1'b0;
        wr_slot = rd_slot;
        unique case (r_item.operation)
            OP_START: begin
                hit = !v_bit;
                wr_en = r_ev_on && !v_bit;
                wr_slot.event_id  = r_item.event_id;
                wr_slot.client_id = r_item.client_id;
                wr_slot.duration  = r_item.amount_ms;
                wr_slot.repeat_en = r_item.periodic;
                wr_slot.elapsed   = '0;
            end
            OP_STOP: begin
                hit = v_bit && (rd_slot.event_id == r_item.event_id);
            end
            OP_TICK: begin
                fire  = r_ev_on && adv && !diff[ELAPSED_W];
                wr_en = r_ev_on && adv;
                wr_slot.elapsed = (fire && rd_slot.repeat_en) ? diff[ELAPSED_W-1:0] : sum;
            end
            default: begin
            end
        endcase
    end

    assign stop_scan = r_ev_on && hit;
    assign scan_done = !r_issue_on && !r_ev_on;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_active   <= ACTIVE_RST;
            r_valid    <= '0;
            r_issue_on <= 1'b0;
            r_ev_on    <= 1'b0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_active <= i_cfg_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_out_vld <= 1'b0;
                    if (start) begin
                        r_state     <= S_SCAN;
                        r_item      <= i_item;
                        r_issue_idx <= '0;
                        r_last_idx  <= IW'(scan_n - NW'(1));
                        r_issue_on  <= (scan_n != '0);
                        r_ev_on     <= 1'b0;
                        r_pend_vld  <= 1'b0;
                    end
                end
                S_SCAN: begin
                    // read stage
                    r_ev_idx <= r_issue_idx;
                    if (r_issue_on) begin
                        r_issue_idx <= r_issue_idx + IW'(1);
                    end
                    // evaluate stage
                    if (stop_scan) begin
                        r_valid[r_ev_idx] <= (r_item.operation == OP_START);
                        r_issue_on        <= 1'b0;
                        r_ev_on           <= 1'b0;
                    end else begin
                        r_ev_on <= r_issue_on;
                        if (r_issue_on && r_issue_idx == r_last_idx) begin
                            r_issue_on <= 1'b0;
                        end
                    end
                    if (fire) begin
                        r_out_vld <= r_pend_vld;
                        if (r_pend_vld) begin
                            r_out <= r_pend;
                        end
                        r_pend_vld <= 1'b1;
                        r_pend     <= '{fired_event: rd_slot.event_id,
                                        fired_client: rd_slot.client_id, last: 1'b0};
                    end else if (scan_done) begin
                        r_state    <= S_IDLE;
                        r_out_vld  <= r_pend_vld;
                        r_pend_vld <= 1'b0;
                        if (r_pend_vld) begin
                            r_out <= '{fired_event: r_pend.fired_event,
                                       fired_client: r_pend.fired_client, last: 1'b1};
                        end
                    end else begin
                        r_out_vld <= 1'b0;
                    end
                end
                default: begin
                    r_state   <= S_IDLE;
                    r_out_vld <= 1'b0;
                end
            endcase
        end
    end

    assign busy        = (r_state != S_IDLE);
    assign o_res_valid = r_out_vld;
    assign o_res       = r_out;

endmodule
